[rtl/szod_pkg.sv]
// Shared types, constants and sine table for the scan zone obstacle detector.
`timescale 1ns / 1ps
package szod_pkg;

  localparam int MAX_POINTS      = 2048;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SIN_N           = 1 << SINE_TABLE_BITS;
  localparam int SIN_Q           = SIN_N / 4;
  localparam int QAW             = SINE_TABLE_BITS - 2;
  localparam int HIT_W           = $clog2(MAX_POINTS);
  localparam logic [HIT_W-1:0] HIT_MAX = HIT_W'(MAX_POINTS - 1);
  localparam int MIN_W           = 17;
  localparam logic [MIN_W-1:0] MIN_NONE = '1;
  localparam int THR_W           = 12;
  localparam int SKIP_W          = 5;
  localparam int PHASE_W         = 4;
  localparam logic [SKIP_W-1:0] SKIP_MAX = SKIP_W'(16);
  localparam logic [14:0] SIN_MAX = 15'd32767;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  localparam int PQ_DEPTH = 4;
  localparam int PQ_AW    = $clog2(PQ_DEPTH);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_BOX  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEC_BOX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AVOID_BOX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP      = 3'd4;

  typedef enum logic [1:0] {
    VERD_TRAVEL = 2'd0,
    VERD_DEC    = 2'd1,
    VERD_STOP   = 2'd2
  } verdict_t;

  // Bounds packed as in the register: x_min in bits 15:0, y_max in bits 63:48.
  typedef struct packed {
    logic signed [15:0] y_max;
    logic signed [15:0] y_min;
    logic signed [15:0] x_max;
    logic signed [15:0] x_min;
  } box_t;

  typedef struct packed {
    box_t              stop_box;
    box_t              dec_box;
    box_t              avoid_box;
    logic [SKIP_W-1:0] skip_interval;
  } front_cfg_t;

  typedef struct packed {
    logic inx_stop;
    logic iny_stop;
    logic inx_avoid;
    logic iny_avoid;
    logic inx_dec;
    logic iny_dec;
  } zone_flags_t;

  typedef struct packed {
    logic [15:0]        range_mm;
    logic [15:0]        angle;
    logic               last_point;
    logic               keep;
    logic signed [15:0] x;
    logic signed [15:0] y;
    zone_flags_t        zones;
  } point_t;

  typedef logic [14:0] qsin_tab_t [SIN_Q];

  function automatic logic [14:0] quarter_sine(input logic [63:0] m);
    logic [63:0] th, x2, t1, t2, t3, t4, t5, t6, t7, t8;
    logic signed [63:0] sum;
    th = (m * TWO_PI_Q30) >> SINE_TABLE_BITS;
    x2 = (th * th) >> 30;
    t1 = th;
    t2 = ((t1 * x2) >> 30) / 64'd6;
    t3 = ((t2 * x2) >> 30) / 64'd20;
    t4 = ((t3 * x2) >> 30) / 64'd42;
    t5 = ((t4 * x2) >> 30) / 64'd72;
    t6 = ((t5 * x2) >> 30) / 64'd110;
    t7 = ((t6 * x2) >> 30) / 64'd156;
    t8 = ((t7 * x2) >> 30) / 64'd210;
    sum = $signed(t1) - $signed(t2) + $signed(t3) - $signed(t4)
        + $signed(t5) - $signed(t6) + $signed(t7) - $signed(t8);
    if (sum < 0) sum = 64'sd0;
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'sd32767) sum = 64'sd32767;
    return sum[14:0];
  endfunction

  function automatic qsin_tab_t build_qsin();
    qsin_tab_t t;
    for (int k = 0; k < SIN_Q; k++) begin
      t[k] = quarter_sine(64'(k));
    end
    return t;
  endfunction

  // First quadrant of the sine, Q0.15; the quarter-turn point is SIN_MAX.
  localparam qsin_tab_t QSIN = build_qsin();

endpackage

[rtl/szod_front.sv]
// Front end: point intake, decimation, polar to cartesian and zone tests.
`timescale 1ns / 1ps
module szod_front (
  input  logic                clk,
  input  logic                rst_n,
  input  szod_pkg::front_cfg_t cfg,
  input  logic                in_push,
  output logic                in_full,
  input  logic [15:0]         in_range_mm,
  input  logic signed [15:0]  in_angle,
  input  logic                in_last_point,
  output logic                pt_push,
  input  logic                pt_full,
  output szod_pkg::point_t    pt_data
);
  import szod_pkg::*;

  function automatic logic signed [15:0] sin_lookup(input logic [SINE_TABLE_BITS-1:0] idx);
    logic [1:0]     quad;
    logic [QAW-1:0] r;
    logic [14:0]    mag;
    logic signed [15:0] s;
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    r    = idx[QAW-1:0];
    if (quad[0]) begin
      mag = (r == '0) ? SIN_MAX : QSIN[QAW'(~r + 1'b1)];
    end else begin
      mag = QSIN[r];
    end
    s = $signed({1'b0, mag});
    return quad[1] ? -s : s;
  endfunction

  // Stage 1: table lookup
  logic               s1_v_r;
  logic [15:0]        s1_range_r, s1_ang_r;
  logic               s1_last_r, s1_keep_r;
  logic signed [15:0] s1_cos_r, s1_sin_r;
  // Stage 2: products
  logic               s2_v_r;
  logic [15:0]        s2_range_r, s2_ang_r;
  logic               s2_last_r, s2_keep_r;
  logic signed [32:0] s2_px_r, s2_py_r;
  // Stage 3: rounded coordinates and zone flags
  logic               s3_v_r;
  point_t             s3_pt_r;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [SKIP_W-1:0]  ivl, phase_inc;
  logic               ld1, ld2, ld3, accept;
  logic [SINE_TABLE_BITS-1:0] sin_idx, cos_idx;
  logic signed [33:0] rx, ry;
  logic signed [17:0] cx, cy;

  assign ld3     = !s3_v_r || !pt_full;
  assign ld2     = !s2_v_r || ld3;
  assign ld1     = !s1_v_r || ld2;
  assign in_full = !ld1;
  assign accept  = in_push && ld1;
  assign pt_push = s3_v_r && !pt_full;
  assign pt_data = s3_pt_r;

  always_comb begin
    if (cfg.skip_interval == '0) begin
      ivl = SKIP_W'(1);
    end else if (cfg.skip_interval > SKIP_MAX) begin
      ivl = SKIP_MAX;
    end else begin
      ivl = cfg.skip_interval;
    end
    phase_inc = SKIP_W'(phase_r) + SKIP_W'(1);
    phase_nxt = (in_last_point || phase_inc >= ivl) ? '0 : phase_inc[PHASE_W-1:0];
  end

  assign sin_idx = in_angle[15 -: SINE_TABLE_BITS];
  assign cos_idx = sin_idx + SINE_TABLE_BITS'(SIN_Q);

  // Round half up to mm: floor((p + 2^14) / 2^15)
  assign rx = 34'(s2_px_r) + 34'sd16384;
  assign ry = 34'(s2_py_r) + 34'sd16384;
  assign cx = rx[32:15];
  assign cy = ry[32:15];

  function automatic logic in_span(input logic signed [15:0] lo,
                                   input logic signed [15:0] hi,
                                   input logic signed [17:0] v);
    return (18'(lo) <= v) && (v <= 18'(hi));
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      phase_r <= '0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
      end
      if (ld1) begin
        s1_v_r <= accept;
      end
      if (ld2) begin
        s2_v_r <= s1_v_r;
      end
      if (ld3) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_range_r <= in_range_mm;
      s1_ang_r   <= in_angle;
      s1_last_r  <= in_last_point;
      s1_keep_r  <= (phase_r == '0);
      s1_cos_r   <= sin_lookup(cos_idx);
      s1_sin_r   <= sin_lookup(sin_idx);
    end
    if (ld2) begin
      s2_range_r <= s1_range_r;
      s2_ang_r   <= s1_ang_r;
      s2_last_r  <= s1_last_r;
      s2_keep_r  <= s1_keep_r;
      s2_px_r    <= $signed({1'b0, s1_range_r}) * s1_cos_r;
      s2_py_r    <= $signed({1'b0, s1_range_r}) * s1_sin_r;
    end
    if (ld3) begin
      s3_pt_r.range_mm        <= s2_range_r;
      s3_pt_r.angle           <= s2_ang_r;
      s3_pt_r.last_point      <= s2_last_r;
      s3_pt_r.keep            <= s2_keep_r;
      s3_pt_r.x               <= cx[15:0];
      s3_pt_r.y               <= cy[15:0];
      s3_pt_r.zones.inx_stop  <= in_span(cfg.stop_box.x_min, cfg.stop_box.x_max, cx);
      s3_pt_r.zones.iny_stop  <= in_span(cfg.stop_box.y_min, cfg.stop_box.y_max, cy);
      s3_pt_r.zones.inx_avoid <= in_span(cfg.avoid_box.x_min, cfg.avoid_box.x_max, cx);
      s3_pt_r.zones.iny_avoid <= in_span(cfg.avoid_box.y_min, cfg.avoid_box.y_max, cy);
      s3_pt_r.zones.inx_dec   <= in_span(cfg.dec_box.x_min, cfg.dec_box.x_max, cx);
      s3_pt_r.zones.iny_dec   <= in_span(cfg.dec_box.y_min, cfg.dec_box.y_max, cy);
    end
  end

endmodule

[rtl/szod_pt_fifo.sv]
// Short queue of classified points between the front end and the accumulator.
`timescale 1ns / 1ps
module szod_pt_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  szod_pkg::point_t din,
  input  logic             pop,
  output logic             empty,
  output szod_pkg::point_t dout
);
  import szod_pkg::*;

  point_t           mem_r [PQ_DEPTH];
  logic [PQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PQ_AW:0]   count_r, count_nxt;

  assign full  = (count_r == (PQ_AW+1)'(PQ_DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

[rtl/szod_back.sv]
// Back end: per-scan hit counting, nearest-hit tracking and verdict register.
`timescale 1ns / 1ps
module szod_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [szod_pkg::THR_W-1:0] point_threshold,
  input  logic                     pt_empty,
  output logic                     pt_pop,
  input  szod_pkg::point_t         pt,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [1:0]               out_verdict,
  output logic signed [15:0]       out_obstacle_x,
  output logic signed [15:0]       out_obstacle_y,
  output logic signed [15:0]       out_bearing
);
  import szod_pkg::*;

  verdict_t           lv_r, verdict;
  logic [HIT_W-1:0]   p_hits_r, s_hits_r, p_hits_nxt, s_hits_nxt;
  logic [MIN_W-1:0]   p_min_r, s_min_r, p_min_nxt, s_min_nxt;
  logic [15:0]        p_x_r, p_y_r, p_a_r, s_x_r, s_y_r, s_a_r;
  logic [15:0]        p_x_nxt, p_y_nxt, p_a_nxt, s_x_nxt, s_y_nxt, s_a_nxt;
  logic               out_v_r;
  verdict_t           out_verd_r;
  logic [15:0]        out_x_r, out_y_r, out_b_r;
  logic               prim_inx, prim_iny, p_hit, s_hit;
  logic [THR_W-1:0]   thr;
  logic [15:0]        o_x, o_y, o_b;

  assign pt_pop = !pt_empty && (!pt.last_point || !out_v_r || out_pop);

  always_comb begin
    prim_inx = (lv_r == VERD_STOP) ? pt.zones.inx_avoid : pt.zones.inx_stop;
    prim_iny = (lv_r == VERD_STOP) ? pt.zones.iny_avoid : pt.zones.iny_stop;
    p_hit = pt.keep && prim_inx && prim_iny;
    s_hit = pt.keep && !prim_inx && pt.zones.inx_dec && pt.zones.iny_dec;

    p_hits_nxt = p_hits_r;
    p_min_nxt  = p_min_r;
    p_x_nxt    = p_x_r;
    p_y_nxt    = p_y_r;
    p_a_nxt    = p_a_r;
    s_hits_nxt = s_hits_r;
    s_min_nxt  = s_min_r;
    s_x_nxt    = s_x_r;
    s_y_nxt    = s_y_r;
    s_a_nxt    = s_a_r;
    if (p_hit) begin
      if (p_hits_r != HIT_MAX) p_hits_nxt = p_hits_r + 1'b1;
      if (MIN_W'(pt.range_mm) < p_min_r) begin
        p_min_nxt = MIN_W'(pt.range_mm);
        p_x_nxt   = pt.x;
        p_y_nxt   = pt.y;
        p_a_nxt   = pt.angle;
      end
    end
    if (s_hit) begin
      if (s_hits_r != HIT_MAX) s_hits_nxt = s_hits_r + 1'b1;
      if (MIN_W'(pt.range_mm) < s_min_r) begin
        s_min_nxt = MIN_W'(pt.range_mm);
        s_x_nxt   = pt.x;
        s_y_nxt   = pt.y;
        s_a_nxt   = pt.angle;
      end
    end

    // A zero threshold still needs one hit.
    thr = (point_threshold == '0) ? THR_W'(1) : point_threshold;
    if (THR_W'(p_hits_nxt) >= thr) begin
      verdict = VERD_STOP;
      o_x = p_x_nxt;
      o_y = p_y_nxt;
      o_b = QUARTER_TURN - p_a_nxt;
    end else if (THR_W'(s_hits_nxt) >= thr) begin
      verdict = VERD_DEC;
      o_x = s_x_nxt;
      o_y = s_y_nxt;
      o_b = QUARTER_TURN - s_a_nxt;
    end else begin
      verdict = VERD_TRAVEL;
      o_x = '0;
      o_y = '0;
      o_b = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r     <= VERD_TRAVEL;
      out_v_r  <= 1'b0;
      p_hits_r <= '0;
      s_hits_r <= '0;
      p_min_r  <= MIN_NONE;
      s_min_r  <= MIN_NONE;
      p_x_r    <= '0;
      p_y_r    <= '0;
      p_a_r    <= '0;
      s_x_r    <= '0;
      s_y_r    <= '0;
      s_a_r    <= '0;
    end else begin
      if (out_pop && out_v_r && !(pt_pop && pt.last_point)) out_v_r <= 1'b0;
      if (pt_pop && pt.last_point) begin
        lv_r     <= verdict;
        out_v_r  <= 1'b1;
        p_hits_r <= '0;
        s_hits_r <= '0;
        p_min_r  <= MIN_NONE;
        s_min_r  <= MIN_NONE;
        p_x_r    <= '0;
        p_y_r    <= '0;
        p_a_r    <= '0;
        s_x_r    <= '0;
        s_y_r    <= '0;
        s_a_r    <= '0;
      end else if (pt_pop) begin
        p_hits_r <= p_hits_nxt;
        s_hits_r <= s_hits_nxt;
        p_min_r  <= p_min_nxt;
        s_min_r  <= s_min_nxt;
        p_x_r    <= p_x_nxt;
        p_y_r    <= p_y_nxt;
        p_a_r    <= p_a_nxt;
        s_x_r    <= s_x_nxt;
        s_y_r    <= s_y_nxt;
        s_a_r    <= s_a_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pt_pop && pt.last_point) begin
      out_verd_r <= verdict;
      out_x_r    <= o_x;
      out_y_r    <= o_y;
      out_b_r    <= o_b;
    end
  end

  assign out_empty      = !out_v_r;
  assign out_verdict    = out_verd_r;
  assign out_obstacle_x = out_x_r;
  assign out_obstacle_y = out_y_r;
  assign out_bearing    = out_b_r;

endmodule

[rtl/scan_zone_obstacle_detector.sv]
// Top level of the scan zone obstacle detector: config registers and block wiring.
`timescale 1ns / 1ps
// Usage:
//   Scan points enter through a queue-style port: a transaction happens on a
//   rising edge with in_push high and in_full low. Verdicts leave the same
//   way: the oldest result sits on out_* while out_empty is low and is taken
//   on an edge with out_pop high. Exactly one result is produced for each
//   point that carries in_last_point; other points produce none.
//   Registers are written through cfg_we / cfg_index / cfg_data (index 0 stop
//   box, 1 slowdown box, 2 avoid box, 3 threshold, 4 skip interval); the user
//   must write them only while the block is idle, which the block does not
//   enforce; writes take effect on the next edge. Throughput: one point per
//   cycle while in_full is low. The front end has three stages (sine lookup,
//   multiply, round and zone compare), then a four-entry point queue, then
//   the accumulator, which registers the verdict of each last point.
//   When the receiver stalls, results hold in the output register; the
//   accumulator keeps taking points until the next last point, the point
//   queue and front stages fill, and then in_full rises.
//   Reset (synchronous, rst_n low) empties all stages and queues, returns the
//   registers to their defaults and sets the previous verdict to travel.
module scan_zone_obstacle_detector (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [15:0]                       in_range_mm,
  input  logic signed [15:0]                in_angle,
  input  logic                              in_last_point,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [1:0]                        out_verdict,
  output logic signed [15:0]                out_obstacle_x,
  output logic signed [15:0]                out_obstacle_y,
  output logic signed [15:0]                out_bearing,
  input  logic                              cfg_we,
  input  logic [szod_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [63:0]                       cfg_data
);
  import szod_pkg::*;

  box_t              stop_box_r, dec_box_r, avoid_box_r;
  logic [THR_W-1:0]  thr_r;
  logic [SKIP_W-1:0] skip_r;
  front_cfg_t        fcfg;

  logic   pq_push, pq_full, pq_pop, pq_empty;
  point_t pq_din, pq_dout;

  // Register file: latch the addressed register, drop writes past the list.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_box_r  <= '0;
      dec_box_r   <= '0;
      avoid_box_r <= '0;
      thr_r       <= THR_W'(5);
      skip_r      <= SKIP_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STOP_BOX:  stop_box_r  <= cfg_data;
        REG_DEC_BOX:   dec_box_r   <= cfg_data;
        REG_AVOID_BOX: avoid_box_r <= cfg_data;
        REG_THRESHOLD: thr_r       <= cfg_data[THR_W-1:0];
        REG_SKIP:      skip_r      <= cfg_data[SKIP_W-1:0];
        default: ;
      endcase
    end
  end

  assign fcfg.stop_box      = stop_box_r;
  assign fcfg.dec_box       = dec_box_r;
  assign fcfg.avoid_box     = avoid_box_r;
  assign fcfg.skip_interval = skip_r;

  // Front end: decimate, convert and classify each point against all zones.
  // The stop/avoid choice is left to the accumulator, which owns the verdict.
  szod_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (fcfg),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_range_mm  (in_range_mm),
    .in_angle     (in_angle),
    .in_last_point(in_last_point),
    .pt_push      (pq_push),
    .pt_full      (pq_full),
    .pt_data      (pq_din)
  );

  // Decouple the front pipeline from the accumulator stalls.
  szod_pt_fifo u_pq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (pq_push),
    .full (pq_full),
    .din  (pq_din),
    .pop  (pq_pop),
    .empty(pq_empty),
    .dout (pq_dout)
  );

  // Accumulate hits per scan and issue the verdict on the last point.
  szod_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .point_threshold(thr_r),
    .pt_empty       (pq_empty),
    .pt_pop         (pq_pop),
    .pt             (pq_dout),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_verdict    (out_verdict),
    .out_obstacle_x (out_obstacle_x),
    .out_obstacle_y (out_obstacle_y),
    .out_bearing    (out_bearing)
  );

  // The front end never pushes into a full point queue.
  a_pq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    pq_push |-> !pq_full)
    else $error("point queue overflow");

  // The accumulator never pops an empty point queue.
  a_pq_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pq_pop |-> !pq_empty)
    else $error("point queue underflow");

  // A travel verdict reports no obstacle.
  a_travel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_verdict == VERD_TRAVEL) |->
      (out_obstacle_x == '0 && out_obstacle_y == '0 && out_bearing == '0))
    else $error("travel verdict with nonzero obstacle");

  // A stalled last point holds the queue head until the result slot frees.
  a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (!pq_empty && pq_dout.last_point && !out_empty && !out_pop) |-> !pq_pop)
    else $error("result register overwritten");

endmodule

[tb/sv/szod_verdict_checker.sv]
// Verdict predictor and result checker for the scan zone obstacle detector.
`timescale 1ns / 1ps
module szod_verdict_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  logic                           in_full,
  input  logic [15:0]                    in_range_mm,
  input  logic signed [15:0]             in_angle,
  input  logic                           in_last_point,
  input  logic                           out_empty,
  input  logic                           out_pop,
  input  logic [1:0]                     out_verdict,
  input  logic signed [15:0]             out_obstacle_x,
  input  logic signed [15:0]             out_obstacle_y,
  input  logic signed [15:0]             out_bearing,
  input  logic                           cfg_we,
  input  logic [szod_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data,
  output int                             mismatch_count,
  output int                             verdicts_pending
);
  import szod_pkg::*;

  localparam longint unsigned TURN_Q30 = 64'd6746518852;
  localparam int HIT_CAP = 2047;
  localparam int NO_RANGE = 'h1FFFF;

  typedef struct packed {
    verdict_t           verdict;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] bearing;
  } verdict_rec_t;

  verdict_rec_t verdict_q[$];
  int sine_q15 [SIN_N];

  box_t stop_zone, slow_zone, avoid_zone;
  logic [THR_W-1:0] hit_threshold;
  logic [SKIP_W-1:0] keep_every;

  verdict_t prev_verdict;
  int keep_phase, prim_hits, slow_hits, prim_best, slow_best;
  int prim_x, prim_y, slow_x, slow_y;
  logic [15:0] prim_ang, slow_ang;

  // Taylor series of sin over the first quadrant, Q30 inside, Q15 out.
  function automatic int quadrant_sine(int m);
    longint unsigned th, x2, term;
    longint acc;
    th = (longint'(m) * TURN_Q30) >> SINE_TABLE_BITS;
    x2 = (th * th) >> 30;
    term = th;
    acc = 0;
    for (int n = 1; n <= 8; n++) begin
      if (n % 2 == 1) acc += longint'(term);
      else acc -= longint'(term);
      term = ((term * x2) >> 30) / longint'(4 * n * n + 2 * n);
    end
    if (acc < 0) acc = 0;
    acc = (acc + 16384) >>> 15;
    if (acc > 32767) acc = 32767;
    return int'(acc);
  endfunction

  // Round a Q15 product to whole mm, ties toward plus infinity.
  function automatic int to_mm(longint p);
    return int'((p + 64'sd16384) >>> 15);
  endfunction

  function automatic bit spans_x(box_t b, int v);
    return $signed(b.x_min) <= v && v <= $signed(b.x_max);
  endfunction

  function automatic bit spans_y(box_t b, int v);
    return $signed(b.y_min) <= v && v <= $signed(b.y_max);
  endfunction

  task automatic clear_scan();
    keep_phase = 0;
    prim_hits = 0;
    slow_hits = 0;
    prim_best = NO_RANGE;
    slow_best = NO_RANGE;
    prim_x = 0;
    prim_y = 0;
    slow_x = 0;
    slow_y = 0;
    prim_ang = '0;
    slow_ang = '0;
  endtask

  task automatic note_mismatch(string what, longint got, longint want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // Advance the scan by one point; a last point queues one verdict.
  task automatic take_point(logic [15:0] rng, logic [15:0] ang, logic last);
    int every, need, idx, cs, sn, px, py;
    box_t lead;
    verdict_rec_t rec;
    every = (keep_every == 0) ? 1 : ((keep_every > 16) ? 16 : int'(keep_every));
    need = (hit_threshold == 0) ? 1 : int'(hit_threshold);
    if (keep_phase == 0) begin
      idx = int'(ang >> (16 - SINE_TABLE_BITS));
      cs = sine_q15[(idx + SIN_N / 4) % SIN_N];
      sn = sine_q15[idx];
      px = to_mm(longint'(rng) * cs);
      py = to_mm(longint'(rng) * sn);
      lead = (prev_verdict == VERD_STOP) ? avoid_zone : stop_zone;
      if (spans_x(lead, px)) begin
        if (spans_y(lead, py)) begin
          if (prim_hits < HIT_CAP) prim_hits++;
          if (int'(rng) < prim_best) begin
            prim_best = int'(rng);
            prim_x = px;
            prim_y = py;
            prim_ang = ang;
          end
        end
      end else if (spans_x(slow_zone, px) && spans_y(slow_zone, py)) begin
        if (slow_hits < HIT_CAP) slow_hits++;
        if (int'(rng) < slow_best) begin
          slow_best = int'(rng);
          slow_x = px;
          slow_y = py;
          slow_ang = ang;
        end
      end
    end
    keep_phase++;
    if (keep_phase >= every) keep_phase = 0;
    if (last) begin
      rec = '0;
      if (prim_hits >= need) begin
        rec.verdict = VERD_STOP;
        rec.x = prim_x[15:0];
        rec.y = prim_y[15:0];
        rec.bearing = QUARTER_TURN - prim_ang;
      end else if (slow_hits >= need) begin
        rec.verdict = VERD_DEC;
        rec.x = slow_x[15:0];
        rec.y = slow_y[15:0];
        rec.bearing = QUARTER_TURN - slow_ang;
      end else begin
        rec.verdict = VERD_TRAVEL;
      end
      verdict_q.push_back(rec);
      prev_verdict = rec.verdict;
      clear_scan();
    end
  endtask

  task automatic check_result();
    verdict_rec_t want;
    if (verdict_q.size() == 0) begin
      note_mismatch("verdict with nothing pending", out_verdict, -1);
    end else begin
      want = verdict_q.pop_front();
      if (out_verdict !== want.verdict) note_mismatch("verdict", out_verdict, want.verdict);
      if (out_obstacle_x !== want.x) note_mismatch("obstacle_x", out_obstacle_x, want.x);
      if (out_obstacle_y !== want.y) note_mismatch("obstacle_y", out_obstacle_y, want.y);
      if (out_bearing !== want.bearing) note_mismatch("bearing", out_bearing, want.bearing);
    end
  endtask

  initial begin
    int quad, r, s;
    for (int k = 0; k < SIN_N; k++) begin
      quad = k / (SIN_N / 4);
      r = k % (SIN_N / 4);
      s = (quad % 2 == 1) ? quadrant_sine(SIN_N / 4 - r) : quadrant_sine(r);
      sine_q15[k] = (quad >= 2) ? -s : s;
    end
    mismatch_count = 0;
    verdicts_pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stop_zone = '0;
      slow_zone = '0;
      avoid_zone = '0;
      hit_threshold = THR_W'(5);
      keep_every = SKIP_W'(1);
      prev_verdict = VERD_TRAVEL;
      clear_scan();
      verdict_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STOP_BOX:  stop_zone = cfg_data;
          REG_DEC_BOX:   slow_zone = cfg_data;
          REG_AVOID_BOX: avoid_zone = cfg_data;
          REG_THRESHOLD: hit_threshold = cfg_data[THR_W-1:0];
          REG_SKIP:      keep_every = cfg_data[SKIP_W-1:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) take_point(in_range_mm, in_angle, in_last_point);
      if (out_pop && !out_empty) check_result();
    end
    verdicts_pending = verdict_q.size();
  end

endmodule

[tb/sv/testbench.sv]
// Top of the scan zone obstacle detector testbench: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module testbench;
  import szod_pkg::*;

  // Longest run of cycles with no transaction on either side before giving up.
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_POINTS = 135;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic [15:0] in_range_mm = '0;
  logic signed [15:0] in_angle = '0;
  logic in_last_point = 1'b0;
  logic out_pop = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic in_full, out_empty;
  logic [1:0] out_verdict;
  logic signed [15:0] out_obstacle_x, out_obstacle_y, out_bearing;

  int mismatch_count, verdicts_pending;
  int quiet_cycles = 0;
  int pop_hold = 0;
  bit send_idle_on = 1'b1;
  bit pop_idle_on = 1'b1;

  scan_zone_obstacle_detector uut (.*);

  szod_verdict_checker verdict_check (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: pop every cycle, except for random stall bursts.
  always @(negedge clk) begin
    if (pop_hold > 0) begin
      pop_hold--;
      out_pop <= 1'b0;
    end else if (pop_idle_on && $urandom_range(0, 9) == 0) begin
      pop_hold = $urandom_range(0, 11);
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  // Watchdog: count cycles in which no transaction happens on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("** scan_zone_obstacle_detector: FAILED **");
    $finish;
  end

  function automatic box_t make_box(int x_lo, int x_hi, int y_lo, int y_hi);
    box_t b;
    b.x_min = 16'(x_lo);
    b.x_max = 16'(x_hi);
    b.y_min = 16'(y_lo);
    b.y_max = 16'(y_hi);
    return b;
  endfunction

  // Mostly a plausible zone ahead of the robot; now and then a point box at the
  // origin, the whole plane or raw random bits (which often leave min above max).
  function automatic box_t random_box(int reach);
    int x_lo, y_lo;
    case ($urandom_range(0, 9))
      7: return '0;
      8: return make_box(-32768, 32767, -32768, 32767);
      9: return {$urandom, $urandom};
      default: begin
        x_lo = int'($urandom_range(0, reach)) - reach / 3;
        y_lo = -int'($urandom_range(0, reach / 2));
        return make_box(x_lo, x_lo + int'($urandom_range(0, reach)), y_lo,
                        int'($urandom_range(0, reach / 2)));
      end
    endcase
  endfunction

  // Offer one point; hold it until the block takes it. A random gap may come first.
  task automatic send_point(logic [15:0] rng, logic [15:0] ang, logic last);
    int gap;
    if (send_idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        in_push <= 1'b0;
      end
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_range_mm <= rng;
    in_angle <= ang;
    in_last_point <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // Drop push, wait until every queued verdict has been taken, then pad.
  task automatic settle(int pad);
    @(negedge clk);
    in_push <= 1'b0;
    while (verdicts_pending != 0) @(negedge clk);
    repeat (pad) @(negedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  // Reprogram every register once the block has gone quiet; the pad covers
  // trailing points that produce no verdict but may still be in the pipeline.
  task automatic load_settings(box_t stop_b, box_t dec_b, box_t avoid_b,
                               logic [11:0] thr, logic [4:0] skip);
    settle(8);
    put_reg(REG_STOP_BOX, stop_b);
    put_reg(REG_DEC_BOX, dec_b);
    put_reg(REG_AVOID_BOX, avoid_b);
    put_reg(REG_THRESHOLD, 64'(thr));
    put_reg(REG_SKIP, 64'(skip));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int span, step, sent;
    logic [11:0] thr;
    logic [4:0] skip;
    logic [15:0] ang, rng, prev_rng;
    logic last_flag;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults: all boxes collapse to the origin, threshold five, keep all.
    // Five range-zero points land on the origin and must give a stop.
    send_point(16'd0, 16'h1234, 1'b0);
    send_point(16'd0, 16'h8000, 1'b0);
    send_point(16'd0, 16'h7FFF, 1'b0);
    send_point(16'd0, 16'hC000, 1'b0);
    send_point(16'd0, 16'h0001, 1'b1);

    load_settings(make_box(0, 1000, -400, 400), make_box(-500, 3000, -1500, 1500),
                  make_box(0, 2000, -800, 800), 12'd2, 5'd1);
    // Stop scan: three stop-box hits with a tie on range, one slowdown hit
    // behind the robot, and a far point at almost half a turn.
    send_point(16'd500, 16'h0000, 1'b0);
    send_point(16'd300, 16'h0000, 1'b0);
    send_point(16'd300, 16'h0040, 1'b0);
    send_point(16'd200, 16'h8000, 1'b0);
    send_point(16'd65535, 16'h7FFF, 1'b1);
    // Stopped, so the avoid box is primary. Two slowdown hits; points inside the
    // primary x band but outside its y band must not reach the slowdown box.
    send_point(16'd1500, 16'h0000, 1'b0);
    send_point(16'd2500, 16'h0000, 1'b0);
    send_point(16'd2600, 16'h0000, 1'b0);
    send_point(16'd1000, 16'h4000, 1'b0);
    send_point(16'd3000, 16'hC000, 1'b1);
    // Travel: nothing reaches the threshold, coordinates beyond the signed 16-bit range.
    send_point(16'd65535, 16'h0000, 1'b0);
    send_point(16'd40000, 16'hC000, 1'b0);
    send_point(16'd0, 16'h0000, 1'b1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:  begin thr = 12'd1;    skip = 5'd1;  end
        1:  begin thr = 12'd0;    skip = 5'd0;  end
        2:  begin thr = 12'd3;    skip = 5'd2;  end
        3:  begin thr = 12'd2048; skip = 5'd16; end
        4:  begin thr = 12'd2;    skip = 5'd17; end
        5:  begin thr = 12'd4095; skip = 5'd31; end
        6:  begin thr = 12'd1;    skip = 5'd3;  end
        7:  begin thr = 12'd4;    skip = 5'd1;  end
        8:  begin thr = 12'd2;    skip = 5'd5;  end
        9:  begin thr = 12'd3;    skip = 5'd1;  end
        10: begin thr = 12'd1;    skip = 5'd2;  end
        default: begin thr = 12'd2; skip = 5'd1; end
      endcase
      case (p)
        1: load_settings({$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, thr, skip);
        3: load_settings('0, make_box(-32768, 32767, -32768, 32767), '0, thr, skip);
        default: load_settings(random_box(800), random_box(3000), random_box(1500),
                               thr, skip);
      endcase
      // Some phases run with no stalls at all; the last phase always does.
      send_idle_on = (p != RANDOM_PHASES - 1) && (p % 4 != 2);
      pop_idle_on = send_idle_on;

      sent = 0;
      prev_rng = '0;
      while (sent < PHASE_POINTS) begin
        // Each scan sweeps the angle with a random step; most scans are short.
        span = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 120) : $urandom_range(1, 24);
        ang = 16'($urandom);
        step = $urandom_range(0, 600);
        for (int k = 0; k < span; k++) begin
          case ($urandom_range(0, 9))
            0: rng = 16'($urandom);
            1: rng = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            2: rng = prev_rng;
            default: rng = 16'($urandom_range(0, 3000));
          endcase
          prev_rng = rng;
          // A stray last point now and then breaks a scan in two.
          last_flag = (k == span - 1) || ($urandom_range(0, 39) == 0);
          send_point(rng, ($urandom_range(0, 4) == 0) ? 16'($urandom) : ang, last_flag);
          ang = ang + 16'(step);
          sent++;
        end
        // Hold off now and then until every verdict has drained.
        if ($urandom_range(0, 19) == 0) settle(0);
      end
    end

    settle(16);
    if (mismatch_count == 0) $display("** scan_zone_obstacle_detector: PASSED **");
    else $display("** scan_zone_obstacle_detector: FAILED **");
    $finish;
  end

endmodule

[files.f]
rtl/szod_pkg.sv
rtl/szod_front.sv
rtl/szod_pt_fifo.sv
rtl/szod_back.sv
rtl/scan_zone_obstacle_detector.sv
tb/sv/szod_verdict_checker.sv
tb/sv/testbench.sv
